@@ rtl/core/ckrw_pkg.sv @@
// Shared types, constants and control structs for the cooked header rewriter.
package ckrw_pkg;

    localparam int HEADER_BYTES     = 16;
    localparam int CNT_W            = $clog2(HEADER_BYTES + 1);
    localparam int IDX_W            = $clog2(HEADER_BYTES);
    localparam int MIN_PACKET_BYTES = 12;
    localparam int ETH_HEADER_BYTES = 14;

    localparam logic [15:0] PKT_TYPE_MAX = 16'd6;
    localparam logic [15:0] ADDR_MAX_LEN = 16'd8;
    localparam logic [15:0] HW_ETHER     = 16'h0001;
    localparam logic [15:0] HW_AX25      = 16'h0003;
    localparam logic [15:0] HW_LOOP_A    = 16'h0100;
    localparam logic [15:0] HW_LOOP_B    = 16'h0300;
    localparam logic [15:0] HW_LOOP_C    = 16'h0304;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [15:0] PROTO_IPV6   = 16'h86DD;
    localparam logic [7:0]  DST_TAIL     = 8'h02;
    localparam logic [7:0]  SRC_TAIL     = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } pkt_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       was_rewritten;
    } eth_word_t;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_CHECK,
        ST_BURST
    } ctrl_state_t;

    typedef struct packed {
        logic take;    // accept the offered input word
        logic check;   // validate the buffered header
        logic emit;    // send the next buffered word
    } ckrw_cmd_t;

    typedef struct packed {
        logic             slot_free;
        logic             hdr_fill;
        logic             medium_end;
        logic             burst_final;
        logic [CNT_W-1:0] seen_count;
    } ckrw_sts_t;

endpackage

@@ rtl/core/ckrw_ctrl.sv @@
// Sequencing state machine: collect, header check, buffered burst.
module ckrw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_ready,
    input  ckrw_pkg::ckrw_sts_t sts,
    output ckrw_pkg::ckrw_cmd_t cmd
);

    ckrw_pkg::ctrl_state_t state_reg;
    ckrw_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ckrw_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // outputs
    always_comb
    begin
        pkt_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ckrw_pkg::ST_COLLECT:
            begin
                pkt_ready = sts.slot_free;
                cmd.take  = sts.slot_free && pkt_valid;
            end
            ckrw_pkg::ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ckrw_pkg::ST_BURST:
            begin
                cmd.emit = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ckrw_pkg::ST_COLLECT:
            begin
                if (sts.slot_free && pkt_valid)
                begin
                    priority if (sts.hdr_fill)
                    begin
                        state_next = ckrw_pkg::ST_CHECK;
                    end
                    else if (sts.medium_end)
                    begin
                        state_next = ckrw_pkg::ST_BURST;
                    end
                    else
                    begin
                        state_next = ckrw_pkg::ST_COLLECT;
                    end
                end
            end
            ckrw_pkg::ST_CHECK:
            begin
                state_next = ckrw_pkg::ST_BURST;
            end
            ckrw_pkg::ST_BURST:
            begin
                if (sts.slot_free && sts.burst_final)
                begin
                    state_next = ckrw_pkg::ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ckrw_pkg::ST_COLLECT;
            end
        endcase
    end

endmodule

@@ rtl/core/ckrw_datapath.sv @@
// Header buffer, byte counter, header check, burst selection and output register.
module ckrw_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ckrw_pkg::pkt_word_t  pkt_word,
    input  ckrw_pkg::ckrw_cmd_t  cmd,
    output ckrw_pkg::ckrw_sts_t  sts,
    output logic                 eth_valid,
    input  logic                 eth_ready,
    output ckrw_pkg::eth_word_t  eth_word
);

    localparam int CNT_W = ckrw_pkg::CNT_W;
    localparam int IDX_W = ckrw_pkg::IDX_W;

    logic [7:0]       store_reg [ckrw_pkg::HEADER_BYTES];
    logic [CNT_W-1:0] seen_reg, seen_next;
    logic             conv_reg, conv_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             blast_reg, blast_next;
    logic             out_valid_reg, out_valid_next;
    ckrw_pkg::eth_word_t out_word_reg, out_word_next;

    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] count_inc;
    logic             pass;
    logic             slot_free;
    logic             burst_final;
    logic             hdr_ok;
    logic [15:0]      f_pkt, f_hw, f_alen, f_proto;
    logic [IDX_W-1:0] rd_sel;
    logic             use_const;
    logic [7:0]       const_byte;
    logic [7:0]       burst_byte;

    // a first mark, or no packet open, restarts the count
    assign count_eff   = pkt_word.first_byte ? '0 : seen_reg;
    assign count_inc   = count_eff + CNT_W'(1);
    assign pass        = (count_eff == CNT_W'(ckrw_pkg::HEADER_BYTES));
    assign slot_free   = !out_valid_reg || eth_ready;
    assign burst_final = ({1'b0, idx_reg} + CNT_W'(1)) == len_reg;

    assign sts.slot_free   = slot_free;
    assign sts.hdr_fill    = !pass && (count_inc == CNT_W'(ckrw_pkg::HEADER_BYTES));
    assign sts.medium_end  = !pass && pkt_word.last_byte
                           && (count_inc >= CNT_W'(ckrw_pkg::MIN_PACKET_BYTES))
                           && (count_inc <  CNT_W'(ckrw_pkg::HEADER_BYTES));
    assign sts.burst_final = burst_final;
    assign sts.seen_count  = seen_reg;

    // cooked header fields, big-endian
    assign f_pkt   = {store_reg[0],  store_reg[1]};
    assign f_hw    = {store_reg[2],  store_reg[3]};
    assign f_alen  = {store_reg[4],  store_reg[5]};
    assign f_proto = {store_reg[14], store_reg[15]};

    assign hdr_ok = (f_pkt <= ckrw_pkg::PKT_TYPE_MAX)
                 && (f_hw == ckrw_pkg::HW_ETHER  || f_hw == ckrw_pkg::HW_AX25
                  || f_hw == ckrw_pkg::HW_LOOP_A || f_hw == ckrw_pkg::HW_LOOP_B
                  || f_hw == ckrw_pkg::HW_LOOP_C)
                 && (f_alen <= ckrw_pkg::ADDR_MAX_LEN)
                 && (f_proto == ckrw_pkg::PROTO_IPV4 || f_proto == ckrw_pkg::PROTO_IPV6);

    // converted layout: addr[0..4], 02, addr[0..4], 01, proto
    always_comb
    begin
        rd_sel     = idx_reg;
        use_const  = 1'b0;
        const_byte = ckrw_pkg::DST_TAIL;
        if (conv_reg)
        begin
            priority if (idx_reg < IDX_W'(5))
            begin
                rd_sel = idx_reg + IDX_W'(6);
            end
            else if (idx_reg == IDX_W'(5))
            begin
                use_const  = 1'b1;
                const_byte = ckrw_pkg::DST_TAIL;
            end
            else if (idx_reg < IDX_W'(11))
            begin
                // positions 6..10 read the address bytes at the same places
                rd_sel = idx_reg;
            end
            else if (idx_reg == IDX_W'(11))
            begin
                use_const  = 1'b1;
                const_byte = ckrw_pkg::SRC_TAIL;
            end
            else
            begin
                rd_sel = idx_reg + IDX_W'(2);
            end
        end
    end

    assign burst_byte = use_const ? const_byte : store_reg[rd_sel];

    always_comb
    begin
        seen_next      = seen_reg;
        conv_next      = conv_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        blast_next     = blast_reg;
        out_valid_next = out_valid_reg && !eth_ready;
        out_word_next  = out_word_reg;

        if (cmd.take)
        begin
            if (pass)
            begin
                out_valid_next = 1'b1;
                out_word_next  = '{out_byte: pkt_word.data_byte,
                                   out_last: pkt_word.last_byte,
                                   was_rewritten: conv_reg};
                if (pkt_word.last_byte)
                begin
                    seen_next = '0;
                    conv_next = 1'b0;
                end
            end
            else
            begin
                seen_next = count_inc;
                idx_next  = '0;
                if (count_inc == CNT_W'(ckrw_pkg::HEADER_BYTES))
                begin
                    blast_next = pkt_word.last_byte;
                end
                else if (pkt_word.last_byte)
                begin
                    seen_next  = '0;
                    len_next   = count_inc;
                    blast_next = 1'b1;
                    conv_next  = 1'b0;
                end
            end
        end

        if (cmd.check)
        begin
            conv_next = hdr_ok;
            len_next  = hdr_ok ? CNT_W'(ckrw_pkg::ETH_HEADER_BYTES)
                               : CNT_W'(ckrw_pkg::HEADER_BYTES);
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_word_next  = '{out_byte: burst_byte,
                               out_last: burst_final && blast_reg,
                               was_rewritten: conv_reg};
            idx_next       = idx_reg + IDX_W'(1);
            if (burst_final && blast_reg)
            begin
                seen_next = '0;
                conv_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && !pass)
        begin
            store_reg[count_eff[IDX_W-1:0]] <= pkt_word.data_byte;
        end
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            conv_reg      <= 1'b0;
            idx_reg       <= '0;
            len_reg       <= '0;
            blast_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            conv_reg      <= conv_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            blast_reg     <= blast_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign eth_valid = out_valid_reg;
    assign eth_word  = out_word_reg;

endmodule

@@ rtl/core/cooked_header_to_ethernet_rewriter.sv @@
// Top level: cooked capture header to Ethernet header rewriter.
// Takes a captured packet one byte word at a time and holds its first 16 bytes.
// When the 16th byte lands, the controller checks them as a cooked header
// (packet type 0..6, known hardware type, address length at most 8, IPv4 or IPv6
// protocol); then the buffer drains one word a cycle while the output can take
// it, either as a 14-byte Ethernet header (address bytes 0..4 plus 02, the same
// plus 01, protocol) with was_rewritten set, or as the original 16 bytes. Input
// stalls during the check and the drain; past the header every byte passes at
// one word per cycle, limited only by the output register. Packets of 12..15
// bytes drain unchanged after their last byte, with input stalled meanwhile;
// shorter ones are dropped. A first mark in mid-packet abandons whatever is
// buffered.
module cooked_header_to_ethernet_rewriter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_ready,
    input  ckrw_pkg::pkt_word_t pkt_word,
    output logic                eth_valid,
    input  logic                eth_ready,
    output ckrw_pkg::eth_word_t eth_word
);

    ckrw_pkg::ckrw_cmd_t cmd;
    ckrw_pkg::ckrw_sts_t sts;

    // sequencing: when to accept, check and drain
    ckrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // buffer, header check and output register
    ckrw_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_word  (pkt_word),
        .cmd       (cmd),
        .sts       (sts),
        .eth_valid (eth_valid),
        .eth_ready (eth_ready),
        .eth_word  (eth_word)
    );

    // only one action on the datapath per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.take, cmd.check, cmd.emit}) <= 1)
        else $error("datapath given more than one command");

    // a header check is always followed by the drain, with input held off
    a_check_then_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.check |=> !pkt_ready)
        else $error("input accepted straight after header check");

    // a word is never taken into a full output register
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && pkt_ready) |-> sts.slot_free)
        else $error("input accepted while output register busy");

    // the byte count never passes the header length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        sts.seen_count <= ckrw_pkg::CNT_W'(ckrw_pkg::HEADER_BYTES))
        else $error("byte count beyond header length");

endmodule
